@@ rtl/dcdc_pkg.sv @@
package dcdc_pkg;

    localparam int SAMPLE_WIDTH     = 16;
    localparam int SAMPLE_FRAC_BITS = 6;

    localparam int MODE_W    = 2;
    localparam int VOLT_W    = 15;
    localparam int RLOAD_W   = 16;
    localparam int GAIN_W    = 24;
    localparam int DUTY_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [MODE_W-1:0] MODE_BOOST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BUCK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BB    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HALF  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VREF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RLOAD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KD    = 3'd5;

    localparam logic [VOLT_W-1:0]  RST_VIN   = 15'd768;
    localparam logic [VOLT_W-1:0]  RST_VREF  = 15'd1536;
    localparam logic [RLOAD_W-1:0] RST_RLOAD = 16'd640;

    localparam logic [DUTY_W-1:0] DUTY_ONE  = {1'b1, {(DUTY_W-1){1'b0}}};
    localparam logic [DUTY_W-1:0] DUTY_HALF = DUTY_ONE >> 1;

    localparam int FF_SHIFT = 16 + SAMPLE_FRAC_BITS;

    // Iterative divider for the register-derived terms.
    localparam int CALC_NUM_W = VOLT_W + FF_SHIFT;
    localparam int CALC_DEN_W = VOLT_W + RLOAD_W;
    localparam int CALC_CNT_W = $clog2(CALC_NUM_W);
    localparam int SQ_W       = 2 * VOLT_W;
    localparam int TGT_W      = CALC_NUM_W;
    localparam int FEED_W     = CALC_NUM_W;

    // Sample datapath.
    localparam int D1_W   = SAMPLE_WIDTH + 2;
    localparam int E_W    = TGT_W + 1;
    localparam int SPLIT  = 19;
    localparam int EHI_W  = E_W - SPLIT;
    localparam int ELO_W  = SPLIT + 1;
    localparam int P1_W   = D1_W + GAIN_W;
    localparam int PLO_W  = ELO_W + GAIN_W;
    localparam int PHI_W  = EHI_W + GAIN_W;
    localparam int PE_W   = 62;
    localparam int BP_W   = P1_W + 1;
    localparam int NUM_W  = PE_W + 1;
    localparam int MAG_W  = NUM_W - 1;
    localparam int FSH_W  = NUM_W - 1 - SAMPLE_FRAC_BITS;

    // Pipelined quotient divider.
    localparam int DM_W   = SAMPLE_WIDTH;
    localparam int QBITS  = 18;
    localparam int QPS    = 3;
    localparam int QSTG   = QBITS / QPS;
    localparam logic [QBITS-1:0] QUOT_LIMIT = {1'b1, {(QBITS-1){1'b0}}};

    localparam int PRE_STG = 5;
    localparam int LATENCY = PRE_STG + 1 + QSTG + 1;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [VOLT_W-1:0]        vin;
        logic [VOLT_W-1:0]        vref;
        logic [RLOAD_W-1:0]       rload;
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] kd;
    } t_cfg;

    typedef struct packed {
        logic [TGT_W-1:0]  target;
        logic [FEED_W-1:0] feed;
    } t_prm;

    typedef struct packed {
        logic              neg;
        logic [DUTY_W-1:0] fduty;
    } t_dside;

endpackage

@@ rtl/dcdc_duty_cycle_controller_core.sv @@
// Channel        Ports                                        Transaction
// sample in      i_start, o_busy, i_cap_voltage,              i_start high, o_busy low
//                i_inductor_current
// duty out       o_valid, o_duty                              o_valid high for one cycle
// register write i_cfg_we, i_cfg_idx, i_cfg_wdata             i_cfg_we high
//
// A sample can be taken in every cycle in which o_busy is low; its duty passes through five
// arithmetic stages, the divider's range check, six quotient stages of three bits each and
// the output register before it is on the outputs.
// Reset is synchronous and active low. After reset and after every register write,
// o_busy stays high while a bit-serial divider derives the reference current and the
// feedforward term from the registers.
// The receiver cannot stall the block, so the pipeline never holds.
module dcdc_duty_cycle_controller_core import dcdc_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic signed [SAMPLE_WIDTH-1:0] i_cap_voltage,
    input  logic signed [SAMPLE_WIDTH-1:0] i_inductor_current,
    output logic                           o_valid,
    output logic [DUTY_W-1:0]              o_duty,
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]          i_cfg_wdata
);

    t_cfg r_cfg, n_cfg;
    t_prm w_prm;
    logic w_calc_busy;
    logic w_boost;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:  n_cfg.mode  = i_cfg_wdata[MODE_W-1:0];
                CFG_VIN:   n_cfg.vin   = i_cfg_wdata[VOLT_W-1:0];
                CFG_VREF:  n_cfg.vref  = i_cfg_wdata[VOLT_W-1:0];
                CFG_RLOAD: n_cfg.rload = i_cfg_wdata[RLOAD_W-1:0];
                CFG_KP:    n_cfg.kp    = $signed(i_cfg_wdata[GAIN_W-1:0]);
                CFG_KD:    n_cfg.kd    = $signed(i_cfg_wdata[GAIN_W-1:0]);
                default:   n_cfg       = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= MODE_BOOST;
            r_cfg.vin   <= RST_VIN;
            r_cfg.vref  <= RST_VREF;
            r_cfg.rload <= RST_RLOAD;
            r_cfg.kp    <= '0;
            r_cfg.kd    <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    dcdc_prm_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_kick  (i_cfg_we),
        .i_cfg   (r_cfg),
        .o_busy  (w_calc_busy),
        .o_prm   (w_prm)
    );

    assign o_busy  = w_calc_busy;
    assign w_boost = (r_cfg.mode == MODE_BOOST);

    logic                           r1_val, r2_val, r3_val, r4_val, r5_val;
    logic signed [SAMPLE_WIDTH-1:0] r1_vc, r2_vc, r3_vc, r4_vc;
    logic signed [D1_W-1:0]         r1_d1;
    logic signed [E_W-1:0]          r1_e;
    logic signed [P1_W-1:0]         r2_p1;
    logic signed [PLO_W-1:0]        r2_plo;
    logic signed [PHI_W-1:0]        r2_phi;
    logic signed [PE_W-1:0]         r3_pe;
    logic signed [BP_W-1:0]         r3_bp;
    logic signed [NUM_W-1:0]        r4_num;
    logic [MAG_W-1:0]               r5_mag;
    logic [DM_W-1:0]                r5_dm;
    t_dside                         r5_side;

    logic signed [SAMPLE_WIDTH-1:0] w_vc_eff;
    logic signed [D1_W-1:0]         w_vcx, w_vrefx, w_d1;
    logic signed [E_W-1:0]          w_ilx, w_tgx, w_e;
    logic signed [ELO_W-1:0]        w_e_lo;
    logic signed [EHI_W-1:0]        w_e_hi;
    logic signed [P1_W-1:0]         w_p1;
    logic signed [PLO_W-1:0]        w_plo;
    logic signed [PHI_W-1:0]        w_phi;
    logic signed [PE_W-1:0]         w_pe;
    logic [FEED_W-1:0]              w_base;
    logic signed [BP_W-1:0]         w_bp;
    logic signed [NUM_W-1:0]        w_num;
    logic [MAG_W-1:0]               w_mag;
    logic [DM_W-1:0]                w_dm;
    logic [FSH_W-1:0]               w_fsh;
    t_dside                         w_side;

    always_comb begin
        w_vc_eff = i_cap_voltage;
        if (w_boost && i_cap_voltage == '0) begin
            w_vc_eff = SAMPLE_WIDTH'(1);
        end
        w_vcx   = D1_W'(w_vc_eff);
        w_vrefx = $signed(D1_W'(r_cfg.vref));
        w_d1    = (r_cfg.mode == MODE_BUCK) ? (w_vrefx - w_vcx) : (w_vcx - w_vrefx);
        w_ilx   = E_W'(i_inductor_current);
        w_tgx   = $signed(E_W'(w_prm.target));
        w_e     = w_boost ? (w_ilx - w_tgx) : -w_ilx;
    end

    always_comb begin
        w_e_lo = $signed({1'b0, r1_e[SPLIT-1:0]});
        w_e_hi = $signed(r1_e[E_W-1:SPLIT]);
        w_p1   = r1_d1 * $signed(r_cfg.kp);
        w_plo  = w_e_lo * $signed(r_cfg.kd);
        w_phi  = w_e_hi * $signed(r_cfg.kd);
    end

    always_comb begin
        w_pe   = (PE_W'(r2_phi) <<< SPLIT) + PE_W'(r2_plo);
        w_base = w_boost ? {r_cfg.vin, {FF_SHIFT{1'b0}}} : w_prm.feed;
        w_bp   = BP_W'($signed({1'b0, w_base})) + BP_W'(r2_p1);
        w_num  = NUM_W'(r3_pe) + NUM_W'(r3_bp);
    end

    always_comb begin
        w_mag = r4_num[NUM_W-1] ? MAG_W'(-r4_num) : MAG_W'(r4_num);
        w_dm  = r4_vc[SAMPLE_WIDTH-1] ? DM_W'(-r4_vc) : DM_W'(r4_vc);
        w_fsh = r4_num[NUM_W-2:SAMPLE_FRAC_BITS];
        w_side.neg = r4_num[NUM_W-1] ^ r4_vc[SAMPLE_WIDTH-1];
        if (r4_num[NUM_W-1]) begin
            w_side.fduty = '0;
        end else if (w_fsh > FSH_W'(DUTY_ONE)) begin
            w_side.fduty = DUTY_ONE;
        end else begin
            w_side.fduty = w_fsh[DUTY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_val <= 1'b0;
            r2_val <= 1'b0;
            r3_val <= 1'b0;
            r4_val <= 1'b0;
            r5_val <= 1'b0;
        end else begin
            r1_val <= i_start && !w_calc_busy;
            r2_val <= r1_val;
            r3_val <= r2_val;
            r4_val <= r3_val;
            r5_val <= r4_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_vc   <= w_vc_eff;
        r1_d1   <= w_d1;
        r1_e    <= w_e;
        r2_vc   <= r1_vc;
        r2_p1   <= w_p1;
        r2_plo  <= w_plo;
        r2_phi  <= w_phi;
        r3_vc   <= r2_vc;
        r3_pe   <= w_pe;
        r3_bp   <= w_bp;
        r4_vc   <= r3_vc;
        r4_num  <= w_num;
        r5_mag  <= w_mag;
        r5_dm   <= w_dm;
        r5_side <= w_side;
    end

    logic             w_q_valid;
    logic [QBITS-1:0] w_uq;
    t_dside           w_q_side;
    logic [DUTY_W-1:0] w_bduty;
    logic [DUTY_W-1:0] n_duty;
    logic              r_valid;
    logic [DUTY_W-1:0] r_duty;

    dcdc_qdiv u_qdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_val),
        .i_mag   (r5_mag),
        .i_dm    (r5_dm),
        .i_side  (r5_side),
        .o_valid (w_q_valid),
        .o_uq    (w_uq),
        .o_side  (w_q_side)
    );

    always_comb begin
        if (w_q_side.neg) begin
            w_bduty = DUTY_ONE;
        end else if (w_uq >= QBITS'(DUTY_ONE)) begin
            w_bduty = '0;
        end else begin
            w_bduty = DUTY_W'(QBITS'(DUTY_ONE) - w_uq);
        end
        unique case (r_cfg.mode)
            MODE_BOOST: n_duty = w_bduty;
            MODE_BUCK:  n_duty = w_q_side.fduty;
            MODE_BB:    n_duty = w_q_side.fduty;
            MODE_HALF:  n_duty = DUTY_HALF;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_duty <= n_duty;
    end

    assign o_valid = r_valid;
    assign o_duty  = r_duty;

`ifndef SYNTHESIS
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_duty <= DUTY_ONE))
        else $error("duty beyond full scale");

    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_valid)
        else $error("accepted sample produced no duty");

    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, LATENCY))
        else $error("duty without an accepted sample");
`endif

endmodule

@@ rtl/dcdc_prm_calc.sv @@
module dcdc_prm_calc import dcdc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_kick,
    input  t_cfg i_cfg,
    output logic o_busy,
    output t_prm o_prm
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]            r_state, n_state;
    logic                  r_step, n_step;
    logic [CALC_CNT_W-1:0] r_cnt, n_cnt;
    logic [CALC_NUM_W-1:0] r_num, n_num;
    logic [CALC_DEN_W-1:0] r_den, n_den;
    logic [CALC_DEN_W-1:0] r_rem, n_rem;
    t_prm                  r_prm, n_prm;

    logic [VOLT_W-1:0]   w_vin_d;
    logic [RLOAD_W-1:0]  w_r_d;
    logic [VOLT_W:0]     w_bb_sum;
    logic [VOLT_W:0]     w_bb_d;
    logic [SQ_W-1:0]     w_sq;
    logic [CALC_DEN_W-1:0] w_vr;
    logic [CALC_DEN_W:0] w_trial;
    logic [CALC_DEN_W:0] w_diff;
    logic                w_ge;

    always_comb begin
        w_vin_d  = (i_cfg.vin == '0) ? VOLT_W'(1) : i_cfg.vin;
        w_r_d    = (i_cfg.rload == '0) ? RLOAD_W'(1) : i_cfg.rload;
        w_bb_sum = {1'b0, i_cfg.vin} + {1'b0, i_cfg.vref};
        w_bb_d   = (w_bb_sum == '0) ? (VOLT_W+1)'(1) : w_bb_sum;
        w_sq     = i_cfg.vref * i_cfg.vref;
        w_vr     = w_vin_d * w_r_d;
        w_trial  = {r_rem, r_num[CALC_NUM_W-1]};
        w_ge     = (w_trial >= {1'b0, r_den});
        w_diff   = w_trial - {1'b0, r_den};
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_num   = r_num;
        n_den   = r_den;
        n_rem   = r_rem;
        n_prm   = r_prm;
        unique case (r_state)
            ST_IDLE: begin
                n_state = ST_IDLE;
            end
            ST_LOAD: begin
                n_rem   = '0;
                n_cnt   = CALC_CNT_W'(CALC_NUM_W - 1);
                n_state = ST_RUN;
                if (!r_step) begin
                    n_num = CALC_NUM_W'({w_sq, {SAMPLE_FRAC_BITS{1'b0}}});
                    n_den = w_vr;
                end else begin
                    n_num = {i_cfg.vref, {FF_SHIFT{1'b0}}};
                    n_den = (i_cfg.mode == MODE_BUCK) ? CALC_DEN_W'(w_vin_d)
                                                      : CALC_DEN_W'(w_bb_d);
                end
            end
            ST_RUN: begin
                n_rem = w_ge ? w_diff[CALC_DEN_W-1:0] : w_trial[CALC_DEN_W-1:0];
                n_num = {r_num[CALC_NUM_W-2:0], w_ge};
                if (r_cnt == '0) begin
                    if (!r_step) begin
                        n_prm.target = n_num;
                        n_step       = 1'b1;
                        n_state      = ST_LOAD;
                    end else begin
                        n_prm.feed = n_num;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    n_cnt = r_cnt - CALC_CNT_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_kick) begin
            n_state = ST_LOAD;
            n_step  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_step  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_prm <= n_prm;
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_prm  = r_prm;

endmodule

@@ rtl/dcdc_qdiv.sv @@
module dcdc_qdiv import dcdc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [MAG_W-1:0] i_mag,
    input  logic [DM_W-1:0]  i_dm,
    input  t_dside           i_side,
    output logic             o_valid,
    output logic [QBITS-1:0] o_uq,
    output t_dside           o_side
);

    logic             r_val  [0:QSTG];
    logic             r_sat  [0:QSTG];
    t_dside           r_side [0:QSTG];
    logic [QBITS-1:0] r_sh   [0:QSTG];
    logic [DM_W-1:0]  r_rem  [0:QSTG];
    logic [DM_W-1:0]  r_dm   [0:QSTG];

    logic             n_sat0;
    logic [QBITS-1:0] n_sh  [0:QSTG-1];
    logic [DM_W-1:0]  n_rem [0:QSTG-1];

    always_comb begin
        logic [DM_W:0]    trial;
        logic [DM_W-1:0]  rem;
        logic [QBITS-1:0] sh;
        trial  = '0;
        rem    = '0;
        sh     = '0;
        n_sat0 = (|i_mag[MAG_W-1:QBITS+DM_W])
              || (i_mag[QBITS+DM_W-1:0] >= {i_dm, {QBITS{1'b0}}});
        for (int k = 0; k < QSTG; k++) begin
            rem = r_rem[k];
            sh  = r_sh[k];
            for (int j = 0; j < QPS; j++) begin
                trial = {rem, sh[QBITS-1]};
                if (trial >= {1'b0, r_dm[k]}) begin
                    rem = DM_W'(trial - {1'b0, r_dm[k]});
                    sh  = {sh[QBITS-2:0], 1'b1};
                end else begin
                    rem = trial[DM_W-1:0];
                    sh  = {sh[QBITS-2:0], 1'b0};
                end
            end
            n_rem[k] = rem;
            n_sh[k]  = sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QSTG; k++) begin
                r_val[k] <= 1'b0;
            end
        end else begin
            r_val[0] <= i_valid;
            for (int k = 0; k < QSTG; k++) begin
                r_val[k+1] <= r_val[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sat[0]  <= n_sat0;
        r_side[0] <= i_side;
        r_dm[0]   <= i_dm;
        r_rem[0]  <= i_mag[QBITS+DM_W-1:QBITS];
        r_sh[0]   <= i_mag[QBITS-1:0];
        for (int k = 0; k < QSTG; k++) begin
            r_sat[k+1]  <= r_sat[k];
            r_side[k+1] <= r_side[k];
            r_dm[k+1]   <= r_dm[k];
            r_rem[k+1]  <= n_rem[k];
            r_sh[k+1]   <= n_sh[k];
        end
    end

    assign o_valid = r_val[QSTG];
    assign o_side  = r_side[QSTG];
    assign o_uq    = (r_sat[QSTG] || (r_sh[QSTG] > QUOT_LIMIT)) ? QUOT_LIMIT : r_sh[QSTG];

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import dcdc_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
    localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};

    class duty_scoreboard;
        t_cfg regs;
        logic [DUTY_W-1:0] duty_q[$];
        int unsigned fail_count;

        function new();
            regs.mode  = MODE_BOOST;
            regs.vin   = RST_VIN;
            regs.vref  = RST_VREF;
            regs.rload = RST_RLOAD;
            regs.kp    = '0;
            regs.kd    = '0;
            fail_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MODE:  regs.mode  = data[MODE_W-1:0];
                CFG_VIN:   regs.vin   = data[VOLT_W-1:0];
                CFG_VREF:  regs.vref  = data[VOLT_W-1:0];
                CFG_RLOAD: regs.rload = data[RLOAD_W-1:0];
                CFG_KP:    regs.kp    = data[GAIN_W-1:0];
                CFG_KD:    regs.kd    = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function longint gain_product(longint g, longint x);
            longint p;
            longint lim;
            lim = 64'sd1 <<< 61;
            p = g * x;
            if (p > lim) begin
                p = lim;
            end else if (p < -lim) begin
                p = -lim;
            end
            return p;
        endfunction

        function logic [DUTY_W-1:0] limit_duty(longint d);
            if (d < 0) begin
                return '0;
            end
            if (d > longint'(DUTY_ONE)) begin
                return DUTY_ONE;
            end
            return d[DUTY_W-1:0];
        endfunction

        function logic [DUTY_W-1:0] predict_duty(logic signed [SAMPLE_WIDTH-1:0] vc_s,
                                                 logic signed [SAMPLE_WIDTH-1:0] il_s);
            longint vc, il, vin, vref, rl, kp, kd, divisor, target, num, sum, q;
            longint unsigned mag_num, mag_vc, uq;
            vc   = longint'(vc_s);
            il   = longint'(il_s);
            vin  = longint'(regs.vin);
            vref = longint'(regs.vref);
            rl   = longint'(regs.rload);
            kp   = longint'(regs.kp);
            kd   = longint'(regs.kd);
            case (regs.mode)
                MODE_BOOST: begin
                    divisor = ((vin == 0) ? 64'sd1 : vin) * ((rl == 0) ? 64'sd1 : rl);
                    target = ((vref * vref) <<< SAMPLE_FRAC_BITS) / divisor;
                    if (vc == 0) begin
                        vc = 64'sd1;
                    end
                    num = (vin <<< FF_SHIFT) + gain_product(kp, vc - vref)
                        + gain_product(kd, il - target);
                    mag_num = (num < 0) ? -num : num;
                    mag_vc  = (vc < 0) ? -vc : vc;
                    uq = mag_num / mag_vc;
                    if (uq > QUOT_LIMIT) begin
                        uq = 64'(QUOT_LIMIT);
                    end
                    q = ((num < 0) != (vc < 0)) ? -$signed(uq) : $signed(uq);
                    return limit_duty(longint'(DUTY_ONE) - q);
                end
                MODE_BUCK: begin
                    divisor = (vin == 0) ? 64'sd1 : vin;
                    sum = ((vref <<< FF_SHIFT) / divisor) + gain_product(kp, vref - vc)
                        - gain_product(kd, il);
                    return (sum < 0) ? '0 : limit_duty(sum >>> SAMPLE_FRAC_BITS);
                end
                MODE_BB: begin
                    divisor = vref + vin;
                    if (divisor == 0) begin
                        divisor = 64'sd1;
                    end
                    sum = ((vref <<< FF_SHIFT) / divisor) + gain_product(kp, vc - vref)
                        - gain_product(kd, il);
                    return (sum < 0) ? '0 : limit_duty(sum >>> SAMPLE_FRAC_BITS);
                end
                default: return DUTY_HALF;
            endcase
        endfunction

        function void note_sample(logic signed [SAMPLE_WIDTH-1:0] vc,
                                  logic signed [SAMPLE_WIDTH-1:0] il);
            duty_q.push_back(predict_duty(vc, il));
        endfunction

        function void check_duty(logic [DUTY_W-1:0] actual);
            logic [DUTY_W-1:0] expected;
            if (duty_q.size() == 0) begin
                $display("%0t: duty %0d arrived with no sample outstanding", $time, actual);
                fail_count++;
            end else begin
                expected = duty_q.pop_front();
                if (actual !== expected) begin
                    $display("%0t: duty mismatch, expected %0d, actual %0d",
                             $time, expected, actual);
                    fail_count++;
                end
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_start;
    logic                           o_busy;
    logic signed [SAMPLE_WIDTH-1:0] i_cap_voltage;
    logic signed [SAMPLE_WIDTH-1:0] i_inductor_current;
    logic                           o_valid;
    logic [DUTY_W-1:0]              o_duty;
    logic                           i_cfg_we;
    logic [CFG_IDX_W-1:0]           i_cfg_idx;
    logic [CFG_DATA_W-1:0]          i_cfg_wdata;

    duty_scoreboard sb;
    int             idle_pct;
    int             stall_cycles = 0;

    dcdc_duty_cycle_controller_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_cap_voltage      (i_cap_voltage),
        .i_inductor_current (i_inductor_current),
        .o_valid            (o_valid),
        .o_duty             (o_duty),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy) begin
            sb.note_sample(i_cap_voltage, i_inductor_current);
        end
        if (i_rst_n && o_valid) begin
            sb.check_duty(o_duty);
        end
        if ((i_start && !o_busy) || o_valid || i_cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_sample(logic signed [SAMPLE_WIDTH-1:0] vc,
                               logic signed [SAMPLE_WIDTH-1:0] il);
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            do begin
                @(negedge i_clk);
            end while ($urandom_range(99) < idle_pct);
        end
        i_start            <= 1'b1;
        i_cap_voltage      <= vc;
        i_inductor_current <= il;
        @(posedge i_clk);
        while (o_busy) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic write_one(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Registers change only once every duty already in flight has come out.
    task automatic program_regs(t_cfg c);
        i_start <= 1'b0;
        while (sb.duty_q.size() != 0) begin
            @(negedge i_clk);
        end
        write_one(CFG_MODE, CFG_DATA_W'(c.mode));
        write_one(CFG_VIN, CFG_DATA_W'(c.vin));
        write_one(CFG_VREF, CFG_DATA_W'(c.vref));
        write_one(CFG_RLOAD, CFG_DATA_W'(c.rload));
        write_one(CFG_KP, c.kp);
        write_one(CFG_KD, c.kd);
        write_one(CFG_IDX_W'(CFG_KD + 1 + $urandom_range(1)), CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [VOLT_W-1:0] pick_volt();
        case ($urandom_range(9))
            0: return '0;
            1: return VOLT_W'(1);
            2: return '1;
            3: return VOLT_W'($urandom);
            default: return VOLT_W'($urandom_range(2048, 32));
        endcase
    endfunction

    function automatic logic signed [GAIN_W-1:0] pick_gain();
        case ($urandom_range(7))
            0: return GAIN_MIN;
            1: return GAIN_MAX;
            2: return '0;
            3: return GAIN_W'($urandom);
            default: return GAIN_W'(int'($urandom_range(524288)) - 262144);
        endcase
    endfunction

    function automatic t_cfg random_cfg(int phase);
        t_cfg c;
        c.mode = MODE_W'(phase % 4);
        if (phase == 0) begin
            c.vin   = '1;
            c.vref  = '1;
            c.rload = '1;
            c.kp    = GAIN_MAX;
            c.kd    = GAIN_MAX;
        end else if (phase == 1) begin
            c.vin   = '0;
            c.vref  = '0;
            c.rload = '0;
            c.kp    = GAIN_MIN;
            c.kd    = GAIN_MIN;
        end else begin
            c.vin  = pick_volt();
            c.vref = pick_volt();
            case ($urandom_range(9))
                0: c.rload = '0;
                1: c.rload = RLOAD_W'(1);
                2: c.rload = '1;
                default: c.rload = RLOAD_W'($urandom_range(6400, 64));
            endcase
            c.kp = pick_gain();
            c.kd = pick_gain();
        end
        return c;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] near_sample(int centre, int spread);
        int v;
        case ($urandom_range(7))
            0: return SAMPLE_WIDTH'($urandom);
            1: return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
            2: return '0;
            default: begin
                v = centre + int'($urandom_range(2 * spread)) - spread;
                if (v > int'(SAMPLE_MAX)) begin
                    v = int'(SAMPLE_MAX);
                end else if (v < int'(SAMPLE_MIN)) begin
                    v = int'(SAMPLE_MIN);
                end
                return SAMPLE_WIDTH'(v);
            end
        endcase
    endfunction

    initial begin
        t_cfg c;
        int   idle_levels[3];
        idle_levels = '{0, 71, 9};
        sb = new();
        idle_pct           = 0;
        i_rst_n            = 1'b0;
        i_start            = 1'b0;
        i_cap_voltage      = '0;
        i_inductor_current = '0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_wdata        = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int m = 0; m < 4; m++) begin
            if (m != 0) begin
                c = sb.regs;
                c.mode = MODE_W'(m);
                program_regs(c);
            end
            idle_pct = idle_levels[m % 3];
            send_sample('0, '0);
            send_sample(SAMPLE_MIN, SAMPLE_MIN);
            send_sample(SAMPLE_MAX, SAMPLE_MAX);
            send_sample(SAMPLE_WIDTH'(1), SAMPLE_WIDTH'(-1));
            send_sample(SAMPLE_WIDTH'(-1), SAMPLE_MAX);
            send_sample(SAMPLE_WIDTH'(sb.regs.vref), '0);
        end

        for (int phase = 0; phase < 20; phase++) begin
            program_regs(random_cfg(phase));
            idle_pct = idle_levels[phase % 3];
            for (int k = 0; k < 100; k++) begin
                send_sample(near_sample(int'(sb.regs.vref), 600), near_sample(0, 2048));
            end
        end

        i_start <= 1'b0;
        while (sb.duty_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (LATENCY + 8) @(negedge i_clk);
        if (sb.fail_count == 0 && sb.duty_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
